/* hdl/xdlzss_pkg.sv */
// ----------------------------------------------------------------------------
// xdlzss_pkg
// Shared types and constants for the descrambling LZSS decoder.
// ----------------------------------------------------------------------------
package xdlzss_pkg;

   // Default history window depth in bytes.
   localparam int unsigned WINDOW_SIZE_DEF = 4096;

   // Window bytes kept free before the write start (start = size - 18).
   localparam int unsigned WIN_START_GAP = 18;

   // Width of the configuration register index.
   localparam int unsigned CSR_IDX_W = 1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_LENGTH     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DESCRAMBLE_ENABLE = 1'b1;

   // Marker bit placed above a freshly loaded flag byte.
   localparam logic [8:0] FLAG_MARK = 9'h100;

   // A match length field is stored with this bias removed.
   localparam logic [4:0] MATCH_BIAS = 5'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;       // take the input item this cycle
      logic emit_lit;     // produce the held literal byte
      logic emit_match;   // produce the window byte at the read pointer
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic go_lit;       // the offered item is a literal to produce
      logic go_match;     // the offered item completes a match token
      logic out_free;     // the result register can take a new item
      logic emit_ok;      // the output limit allows another byte
      logic match_last;   // this match byte ends the run
   } status_type;

   // Controller states, one-hot.
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_LIT  = 4'b0010,
      ST_MRD  = 4'b0100,
      ST_MWR  = 4'b1000
   } state_type;

endpackage

/* hdl/xdlzss_ctrl.sv */
// ----------------------------------------------------------------------------
// xdlzss_ctrl
// Controller state machine: sequences item intake, literal output and the
// read/write steps of a match copy.
// ----------------------------------------------------------------------------
module xdlzss_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  xdlzss_pkg::status_type sts,
   output xdlzss_pkg::cmd_type    cmd
);

   xdlzss_pkg::state_type state_ff, state_in;

   // Input items are taken only between decode operations.
   assign req_stall = (state_ff != xdlzss_pkg::ST_IDLE);

   // Next state and commands.
   always_comb begin
      state_in       = state_ff;
      cmd.accept     = 1'b0;
      cmd.emit_lit   = 1'b0;
      cmd.emit_match = 1'b0;
      unique case (state_ff)
         xdlzss_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (sts.go_lit) begin
                  state_in = xdlzss_pkg::ST_LIT;
               end else if (sts.go_match) begin
                  state_in = xdlzss_pkg::ST_MRD;
               end
            end
         end
         xdlzss_pkg::ST_LIT: begin
            if (sts.out_free) begin
               cmd.emit_lit = 1'b1;
               state_in     = xdlzss_pkg::ST_IDLE;
            end
         end
         xdlzss_pkg::ST_MRD: begin
            // Window read is in flight; data is ready next cycle.
            state_in = xdlzss_pkg::ST_MWR;
         end
         xdlzss_pkg::ST_MWR: begin
            if (sts.out_free) begin
               cmd.emit_match = 1'b1;
               if (!sts.emit_ok || sts.match_last) begin
                  state_in = xdlzss_pkg::ST_IDLE;
               end else begin
                  state_in = xdlzss_pkg::ST_MRD;
               end
            end
         end
         default: begin
            state_in = xdlzss_pkg::ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= xdlzss_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hdl/xdlzss_dp.sv */
// ----------------------------------------------------------------------------
// xdlzss_dp
// Datapath: configuration registers, descrambler, flag and token parser,
// history window memory, output limit counting and the result register.
// ----------------------------------------------------------------------------
module xdlzss_dp #(
   parameter int unsigned WINDOW_SIZE = xdlzss_pkg::WINDOW_SIZE_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // Configuration writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [xdlzss_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                      csr_wdata,
   // Input item payload
   input  logic [7:0]                       req_in_byte,
   input  logic                             req_start_stream,
   // Result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [7:0]                       rsp_out_byte,
   output logic                             rsp_last_of_run,
   output logic                             rsp_stream_done,
   // Controller link
   input  xdlzss_pkg::cmd_type              cmd,
   output xdlzss_pkg::status_type           sts
);

   localparam int unsigned AW = $clog2(WINDOW_SIZE);
   localparam logic [AW-1:0] WinStart = AW'(WINDOW_SIZE - xdlzss_pkg::WIN_START_GAP);

   // Configuration registers.
   logic [31:0] out_len_ff;
   logic        desc_en_ff;

   // Parser and stream state.
   logic [8:0]    flag_ff, flag_in;
   logic          phase_ff, phase_in;
   logic [7:0]    off_low_ff, off_low_in;
   logic [7:0]    scr_ff, scr_in;
   logic          fin_ff, fin_in;
   logic [31:0]   count_ff, count_in;
   logic [AW-1:0] wp_ff, wp_in;
   logic [7:0]    lit_ff, lit_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [4:0]    remain_ff, remain_in;

   // Result register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       rsp_done_ff, rsp_done_in;

   // Window memory.
   logic [7:0] win_mem [WINDOW_SIZE];
   logic [7:0] mem_q_ff;

   // Effective state for the offered item (a restart clears it first).
   logic [8:0]    flag_eff;
   logic          phase_eff;
   logic          fin_eff;
   logic [7:0]    scr_eff;
   logic [7:0]    dbyte;

   // Emission helpers.
   logic          emit_req;
   logic          emit_go;
   logic          emit_done;
   logic [AW-1:0] rel_pos;
   logic          rd_written;
   logic [7:0]    emit_data;
   logic          emit_last;

   assign csr_ready = 1'b1;

   // Configuration register writes; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_len_ff <= 32'd0;
         desc_en_ff <= 1'b1;
      end else if (csr_valid) begin
         if (csr_index == xdlzss_pkg::CSR_OUTPUT_LENGTH) begin
            out_len_ff <= csr_wdata;
         end else if (csr_index == xdlzss_pkg::CSR_DESCRAMBLE_ENABLE) begin
            desc_en_ff <= csr_wdata[0];
         end
      end
   end

   // Restart view of the state and the descrambled byte.
   always_comb begin
      flag_eff  = req_start_stream ? 9'd0 : flag_ff;
      phase_eff = req_start_stream ? 1'b0 : phase_ff;
      fin_eff   = req_start_stream ? 1'b0 : fin_ff;
      scr_eff   = req_start_stream ? 8'd0 : scr_ff;
      dbyte     = desc_en_ff ? (req_in_byte ^ scr_eff) : req_in_byte;
   end

   // Entries written since the restart form one run starting at WinStart;
   // anything outside that run still reads as zero.
   always_comb begin
      rel_pos    = rd_ptr_ff - WinStart;
      rd_written = (count_ff[31:AW] != '0) || (rel_pos < count_ff[AW-1:0]);
      emit_data  = cmd.emit_lit ? lit_ff : (rd_written ? mem_q_ff : 8'd0);
   end

   // Output limit and status to the controller.
   always_comb begin
      emit_req         = cmd.emit_lit | cmd.emit_match;
      sts.emit_ok      = !fin_ff && (count_ff < out_len_ff);
      emit_done        = ((count_ff + 32'd1) == out_len_ff);
      emit_go          = emit_req && sts.emit_ok;
      sts.match_last   = (remain_ff == 5'd1) || emit_done;
      emit_last        = cmd.emit_lit | sts.match_last;
      sts.out_free     = !rsp_valid_ff || !rsp_stall;
      sts.go_lit       = !fin_eff && !phase_eff && (flag_eff > 9'd1) && flag_eff[0];
      sts.go_match     = !fin_eff && phase_eff;
   end

   // Next state of the parser, counters and result register.
   always_comb begin
      flag_in      = flag_ff;
      phase_in     = phase_ff;
      off_low_in   = off_low_ff;
      scr_in       = scr_ff;
      fin_in       = fin_ff;
      count_in     = count_ff;
      wp_in        = wp_ff;
      lit_in       = lit_ff;
      rd_ptr_in    = rd_ptr_ff;
      remain_in    = remain_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      // Take an item: restart if asked, descramble, then parse.
      if (cmd.accept) begin
         flag_in    = flag_eff;
         phase_in   = phase_eff;
         fin_in     = fin_eff;
         scr_in     = scr_eff + 8'd1;
         if (req_start_stream) begin
            off_low_in = 8'd0;
            count_in   = 32'd0;
            wp_in      = WinStart;
         end
         if (!fin_eff) begin
            phase_in = 1'b0;
            if (phase_eff) begin
               // Second match byte: high offset nibble and length.
               rd_ptr_in = AW'({dbyte[7:4], off_low_ff});
               remain_in = {1'b0, dbyte[3:0]} + xdlzss_pkg::MATCH_BIAS;
            end else if (flag_eff <= 9'd1) begin
               flag_in = xdlzss_pkg::FLAG_MARK | {1'b0, dbyte};
            end else begin
               flag_in = {1'b0, flag_eff[8:1]};
               if (flag_eff[0]) begin
                  lit_in = dbyte;
               end else begin
                  off_low_in = dbyte;
                  phase_in   = 1'b1;
               end
            end
         end
      end

      // Produce one byte, or stop for good once the limit is reached.
      if (emit_req) begin
         if (emit_go) begin
            wp_in        = wp_ff + AW'(1);
            count_in     = count_ff + 32'd1;
            rsp_valid_in = 1'b1;
            rsp_byte_in  = emit_data;
            rsp_last_in  = emit_last;
            rsp_done_in  = emit_done;
            fin_in       = emit_done;
            if (cmd.emit_match) begin
               rd_ptr_in = rd_ptr_ff + AW'(1);
               remain_in = remain_ff - 5'd1;
            end
         end else begin
            fin_in = 1'b1;
         end
      end
   end

   // Control state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff      <= 9'd0;
         phase_ff     <= 1'b0;
         off_low_ff   <= 8'd0;
         scr_ff       <= 8'd0;
         fin_ff       <= 1'b0;
         count_ff     <= 32'd0;
         wp_ff        <= WinStart;
         rsp_valid_ff <= 1'b0;
      end else begin
         flag_ff      <= flag_in;
         phase_ff     <= phase_in;
         off_low_ff   <= off_low_in;
         scr_ff       <= scr_in;
         fin_ff       <= fin_in;
         count_ff     <= count_in;
         wp_ff        <= wp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      lit_ff      <= lit_in;
      rd_ptr_ff   <= rd_ptr_in;
      remain_ff   <= remain_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      rsp_done_ff <= rsp_done_in;
   end

   // History window: one write port, registered read at the copy pointer.
   always_ff @(posedge clock) begin
      if (emit_go) begin
         win_mem[wp_ff] <= emit_data;
      end
      mem_q_ff <= win_mem[rd_ptr_ff];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_last_of_run = rsp_last_ff;
   assign rsp_stream_done = rsp_done_ff;

endmodule

/* hdl/xor_descramble_lzss_decoder.sv */
// ----------------------------------------------------------------------------
// xor_descramble_lzss_decoder
// Descrambling LZSS decoder with a 4096-byte history window.
// ----------------------------------------------------------------------------
// One compressed byte is taken per item. A flag byte or the first byte of a
// match is only parsed. A literal is parsed on intake and produced afterwards.
// The second match byte starts a copy of 3 to 18 bytes, in which every copied
// byte is a registered read of the window memory followed by its write-back.
// Output stalls can hold back a produced byte. The input is not taken while a
// literal or match is still being produced; a finished result waits in the
// output register. A stream restart needs no clearing pass: a fill count tells
// written window entries from those that still read as zero.
// ----------------------------------------------------------------------------
module xor_descramble_lzss_decoder #(
   parameter int unsigned WINDOW_SIZE = xdlzss_pkg::WINDOW_SIZE_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // Configuration writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [xdlzss_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                      csr_wdata,
   // Compressed byte items
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [7:0]                       req_in_byte,
   input  logic                             req_start_stream,
   // Decompressed byte items
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [7:0]                       rsp_out_byte,
   output logic                             rsp_last_of_run,
   output logic                             rsp_stream_done
);

   xdlzss_pkg::cmd_type    cmd;
   xdlzss_pkg::status_type sts;

   // Sequencer.
   xdlzss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Decode datapath and window.
   xdlzss_dp #(
      .WINDOW_SIZE (WINDOW_SIZE)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_in_byte      (req_in_byte),
      .req_start_stream (req_start_stream),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_stream_done  (rsp_stream_done),
      .cmd              (cmd),
      .sts              (sts)
   );

endmodule

/* tb/xor_descramble_lzss_decoder_checker.sv */
// ----------------------------------------------------------------------------
// xor_descramble_lzss_decoder_checker
// Watches the configuration, compressed byte and decompressed byte channels of
// the descrambling LZSS decoder. It keeps its own copy of the decoder state,
// predicts the bytes that every accepted item should produce, and compares
// each delivered item field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module xor_descramble_lzss_decoder_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [xdlzss_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                      csr_wdata,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic [7:0]                       req_in_byte,
   input  logic                             req_start_stream,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic [7:0]                       rsp_out_byte,
   input  logic                             rsp_last_of_run,
   input  logic                             rsp_stream_done,
   output int unsigned                      fail_count,
   output int unsigned                      pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned WIN_DEPTH = xdlzss_pkg::WINDOW_SIZE_DEF;
   localparam logic [11:0] WIN_START =
      12'(xdlzss_pkg::WINDOW_SIZE_DEF - xdlzss_pkg::WIN_START_GAP);

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       stream_done;
   } dec_result_type;

   // Decoded bytes still owed by the block, oldest first.
   dec_result_type expected_out[$];
   int unsigned mismatches = 0;

   // Register copies.
   logic [31:0] out_len;
   logic        scr_en;

   // Decoder state copy.
   logic [7:0]  hist [WIN_DEPTH];
   logic [8:0]  flags;
   logic        second_byte;
   logic [7:0]  off_lo;
   logic [11:0] wr_pos;
   logic [31:0] produced;
   logic [7:0]  scr_idx;
   logic        done_flag;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   // A stream restart clears the parser, the counters and the whole window.
   task automatic restart_decoder();
      for (int i = 0; i < WIN_DEPTH; i++) hist[i] = 8'h00;
      flags       = 9'h000;
      second_byte = 1'b0;
      off_lo      = 8'h00;
      wr_pos      = WIN_START;
      produced    = 32'd0;
      scr_idx     = 8'h00;
      done_flag   = 1'b0;
   endtask

   // Produce one byte unless the output limit has been reached.
   task automatic put_byte(input logic [7:0] b, output logic ok);
      dec_result_type r;
      if (done_flag || produced >= out_len) begin
         done_flag = 1'b1;
         ok = 1'b0;
      end else begin
         hist[wr_pos] = b;
         wr_pos = wr_pos + 12'd1;
         produced = produced + 32'd1;
         r.out_byte    = b;
         r.last_of_run = 1'b0;
         r.stream_done = (produced == out_len);
         if (r.stream_done) done_flag = 1'b1;
         expected_out.push_back(r);
         ok = 1'b1;
      end
   endtask

   // Work out the bytes that one compressed item produces.
   task automatic decode_byte(input logic [7:0] raw, input logic start);
      logic [7:0]     b;
      logic [11:0]    off;
      int             run_len;
      logic           ok;
      int             n_prior;
      dec_result_type tail;
      if (start) restart_decoder();
      b = scr_en ? (raw ^ scr_idx) : raw;
      scr_idx = scr_idx + 8'd1;
      n_prior = expected_out.size();
      if (!done_flag) begin
         if (second_byte) begin
            // Second match byte: copy byte by byte, so a match may overlap itself.
            off = {b[7:4], off_lo};
            run_len = int'(b[3:0]) + int'(xdlzss_pkg::MATCH_BIAS);
            second_byte = 1'b0;
            for (int i = 0; i < run_len; i++) begin
               put_byte(hist[off + 12'(i)], ok);
               if (!ok) break;
            end
         end else if (flags <= 9'd1) begin
            flags = xdlzss_pkg::FLAG_MARK | {1'b0, b};
         end else if (flags[0]) begin
            flags = flags >> 1;
            put_byte(b, ok);
         end else begin
            flags = flags >> 1;
            off_lo = b;
            second_byte = 1'b1;
         end
      end
      // Mark the final byte this item produced.
      if (expected_out.size() > n_prior) begin
         tail = expected_out.pop_back();
         tail.last_of_run = 1'b1;
         expected_out.push_back(tail);
      end
   endtask

   // Track the channels at each clock edge; results are checked before new
   // predictions are added, since an item never answers in its own cycle.
   always @(posedge clock) begin
      dec_result_type want;
      if (reset) begin
         out_len = 32'd0;
         scr_en  = 1'b1;
         restart_decoder();
         expected_out.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == xdlzss_pkg::CSR_OUTPUT_LENGTH) out_len = csr_wdata;
            else if (csr_index == xdlzss_pkg::CSR_DESCRAMBLE_ENABLE)
               scr_en = csr_wdata[0];
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_out.size() == 0) begin
               report_mismatch("unexpected item", {24'h0, rsp_out_byte}, 32'h0);
            end else begin
               want = expected_out.pop_front();
               if (rsp_out_byte !== want.out_byte)
                  report_mismatch("out_byte", {24'h0, rsp_out_byte}, {24'h0, want.out_byte});
               if (rsp_last_of_run !== want.last_of_run)
                  report_mismatch("last_of_run", {31'h0, rsp_last_of_run},
                                  {31'h0, want.last_of_run});
               if (rsp_stream_done !== want.stream_done)
                  report_mismatch("stream_done", {31'h0, rsp_stream_done},
                                  {31'h0, want.stream_done});
            end
         end
         if (req_valid && !req_stall) decode_byte(req_in_byte, req_start_stream);
      end
      pending    <= expected_out.size();
      fail_count <= mismatches;
   end

endmodule

/* tb/xor_descramble_lzss_decoder_tb.sv */
// ----------------------------------------------------------------------------
// xor_descramble_lzss_decoder_tb
// Drives the descrambling LZSS decoder with directed and random compressed
// streams under several register settings and idle patterns, including a long
// hold-off on the output side, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module xor_descramble_lzss_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RANDOM_ITEMS = 210;
   localparam int unsigned SEGMENT_ITEMS = 35;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned SETTLE_CYCLES = 64;
   localparam int unsigned QUIET_LIMIT = 3000;

   logic                             clock;
   logic                             reset = 1'b1;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [xdlzss_pkg::CSR_IDX_W-1:0] csr_index = xdlzss_pkg::CSR_OUTPUT_LENGTH;
   logic [31:0]                      csr_wdata = 32'd0;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [7:0]                       req_in_byte = 8'h00;
   logic                             req_start_stream = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [7:0]                       rsp_out_byte;
   logic                             rsp_last_of_run;
   logic                             rsp_stream_done;
   int unsigned                      fail_count;
   int unsigned                      pending;

   // Idle rates in percent, and the hold-off request counters.
   int unsigned req_idle_pct = 16;
   int unsigned rsp_idle_pct = 46;
   int unsigned hold_ask = 0;
   int unsigned hold_done = 0;
   int unsigned quiet = 0;

   // Stimulus side view of the stream.
   logic        scram_on = 1'b1;
   logic [7:0]  stream_pos = 8'h00;
   logic [11:0] wr_guess = 12'hFEE;
   longint      out_guess = 0;
   logic [31:0] cur_len = 32'd0;

   xor_descramble_lzss_decoder i_dut (
      .clock, .reset,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata,
      .req_valid, .req_stall, .req_in_byte, .req_start_stream,
      .rsp_valid, .rsp_stall, .rsp_out_byte, .rsp_last_of_run, .rsp_stream_done
   );

   xor_descramble_lzss_decoder_checker i_checker (
      .clock, .reset,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata,
      .req_valid, .req_stall, .req_in_byte, .req_start_stream,
      .rsp_valid, .rsp_stall, .rsp_out_byte, .rsp_last_of_run, .rsp_stream_done,
      .fail_count, .pending
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Output side: random stalls, or a long hold-off when one is requested.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_ask != hold_done) begin
            hold_done = hold_ask;
            for (int n = 0; n < HOLD_CYCLES; n++) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
         end
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   // End the run if no channel moves an item for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   task automatic write_reg(input logic [xdlzss_pkg::CSR_IDX_W-1:0] idx,
                            input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Offer one item, after a random idle gap, and wait until it is taken.
   task automatic send_item(input logic [7:0] raw, input logic start);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_in_byte      <= raw;
      req_start_stream <= start;
      do @(posedge clock); while (req_stall);
   endtask

   // Scramble a plain stream byte with its position when descrambling is on.
   task automatic send_plain(input logic [7:0] plain, input logic start);
      logic [7:0] raw;
      if (start) stream_pos = 8'h00;
      raw = scram_on ? (plain ^ stream_pos) : plain;
      stream_pos = stream_pos + 8'd1;
      send_item(raw, start);
   endtask

   task automatic open_stream(input logic [7:0] flag_byte);
      wr_guess = 12'hFEE;
      out_guess = 0;
      send_plain(flag_byte, 1'b1);
   endtask

   task automatic send_literal(input logic [7:0] b);
      send_plain(b, 1'b0);
      wr_guess = wr_guess + 12'd1;
      out_guess++;
   endtask

   task automatic send_match(input logic [11:0] off, input logic [3:0] len_field);
      send_plain(off[7:0], 1'b0);
      send_plain({off[11:8], len_field}, 1'b0);
      wr_guess = wr_guess + 12'(len_field) + 12'd3;
      out_guess += longint'(len_field) + 3;
   endtask

   // Wait until every predicted byte has arrived and the block has settled.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int unsigned made;
      int unsigned seg_end;
      int unsigned pick;
      int          k;
      logic [7:0]  flags;
      logic [11:0] off;
      logic        in_stream;
      logic        held;

      made = 0;
      held = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Plain stream: literals at both byte extremes, a match into the start
      // of the window, and a long match that overlaps the bytes it writes.
      scram_on = 1'b0;
      write_reg(xdlzss_pkg::CSR_DESCRAMBLE_ENABLE, 32'd0);
      write_reg(xdlzss_pkg::CSR_OUTPUT_LENGTH, 32'hFFFF_FFFF);
      open_stream(8'h05);
      send_literal(8'hFF);
      send_match(12'hFEE, 4'h0);
      send_literal(8'h00);
      send_match(wr_guess - 12'd1, 4'hF);
      wait_idle();

      // Scrambled stream that hits its limit inside a match; the bytes after
      // that are ignored.
      scram_on = 1'b1;
      write_reg(xdlzss_pkg::CSR_DESCRAMBLE_ENABLE, 32'd1);
      write_reg(xdlzss_pkg::CSR_OUTPUT_LENGTH, 32'd6);
      open_stream(8'h01);
      send_literal(8'h3C);
      send_match(12'hFEE, 4'hF);
      send_plain(8'hAA, 1'b0);
      send_plain(8'h55, 1'b0);
      wait_idle();

      // A zero output length produces nothing.
      write_reg(xdlzss_pkg::CSR_OUTPUT_LENGTH, 32'd0);
      open_stream(8'hFF);
      send_literal(8'h81);
      wait_idle();

      // Lowering the length below the count already produced stops the stream.
      write_reg(xdlzss_pkg::CSR_OUTPUT_LENGTH, 32'hFFFF_FFFF);
      open_stream(8'hFF);
      send_literal(8'h01);
      send_literal(8'h80);
      send_literal(8'h7E);
      wait_idle();
      write_reg(xdlzss_pkg::CSR_OUTPUT_LENGTH, 32'd2);
      send_literal(8'hC3);
      wait_idle();

      // Random segments of mostly well-formed streams with some noise.
      while (made < RANDOM_ITEMS) begin
         if (made < RANDOM_ITEMS / 3) begin
            req_idle_pct = 16;
            rsp_idle_pct = 46;
         end else if (made < 2 * RANDOM_ITEMS / 3) begin
            req_idle_pct = 46;
            rsp_idle_pct = 16;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         scram_on = 1'($urandom_range(1));
         case ($urandom_range(3))
            0: cur_len = 32'hFFFF_FFFF;
            1: cur_len = $urandom_range(300, 40);
            2: cur_len = $urandom;
            default: cur_len = $urandom_range(20, 1);
         endcase
         write_reg(xdlzss_pkg::CSR_OUTPUT_LENGTH, cur_len);
         write_reg(xdlzss_pkg::CSR_DESCRAMBLE_ENABLE, {31'd0, scram_on});
         seg_end = made + SEGMENT_ITEMS;
         while (made < seg_end) begin
            flags = 8'($urandom);
            open_stream(flags);
            made++;
            in_stream = 1'b1;
            while (in_stream && made < seg_end) begin
               for (k = 0; k < 8 && in_stream; k++) begin
                  // Once the sender runs freely, hold off the output for a while.
                  if (!held && made >= 150) begin
                     hold_ask++;
                     held = 1'b1;
                  end
                  pick = $urandom_range(99);
                  if (pick < 6) begin
                     send_plain(8'($urandom), 1'b0);
                     made++;
                  end else if (pick < 9) begin
                     in_stream = 1'b0;
                  end else if (flags[k]) begin
                     send_literal(8'($urandom));
                     made++;
                  end else begin
                     if ($urandom_range(3) != 0) off = wr_guess - 12'($urandom_range(24, 1));
                     else off = 12'($urandom);
                     send_match(off, 4'($urandom_range(15)));
                     made += 2;
                  end
                  if (out_guess >= longint'(cur_len)) in_stream = 1'b0;
               end
               if (in_stream) begin
                  flags = 8'($urandom);
                  send_plain(flags, 1'b0);
                  made++;
               end
            end
         end
         wait_idle();
      end

      if (fail_count == 0 && pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
